// ===== design/iffc_pkg.sv =====
// Shared constants and types for the interpolated flat-field correction block.
// No dependencies; imported by iffc_divider and interpolated_flat_field_correction.
package iffc_pkg;

	localparam int PIXEL_BITS_DEF = 16;
	localparam int WEIGHT_BITS    = 20;
	localparam int FRAC_BITS      = 16;
	localparam int TRANS_BITS     = 24;
	localparam int SAT_SHIFT      = 8;
	localparam int ADDR_BITS      = 3;
	localparam int DATA_BITS      = 32;

	localparam logic [ADDR_BITS-3:0] REG_WEIGHT = '0;

	typedef struct packed {
		logic bad;
		logic sat;
		logic frame_end;
	} meta_t;

endpackage

// ===== design/iffc_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on iffc_pkg (meta_t).
module iffc_divider #(
	parameter int DIV_W     = 37,
	parameter int QUOT_BITS = iffc_pkg::TRANS_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_vld,
	input  logic [DIV_W-1:0]     in_rem,
	input  logic [DIV_W-1:0]     in_den,
	input  iffc_pkg::meta_t      in_meta,
	output logic                 out_vld,
	output logic [QUOT_BITS-1:0] out_quot,
	output iffc_pkg::meta_t      out_meta
);
	import iffc_pkg::*;

	logic                 vld_s  [0:QUOT_BITS];
	logic [DIV_W-1:0]     rem_s  [0:QUOT_BITS];
	logic [DIV_W-1:0]     den_s  [0:QUOT_BITS];
	logic [QUOT_BITS-1:0] quot_s [0:QUOT_BITS];
	meta_t                meta_s [0:QUOT_BITS];

	assign vld_s[0]  = in_vld;
	assign rem_s[0]  = in_rem;
	assign den_s[0]  = in_den;
	assign quot_s[0] = '0;
	assign meta_s[0] = in_meta;

	for (genvar k = 0; k < QUOT_BITS; k++) begin : g_stage
		logic [DIV_W:0] dbl;
		logic [DIV_W:0] den_x;
		logic [DIV_W:0] diff;
		logic           ge;

		assign dbl   = {rem_s[k], 1'b0};
		assign den_x = {1'b0, den_s[k]};
		assign diff  = dbl - den_x;
		assign ge    = (dbl >= den_x);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= ge ? diff[DIV_W-1:0] : dbl[DIV_W-1:0];
			den_s[k+1]  <= den_s[k];
			quot_s[k+1] <= {quot_s[k][QUOT_BITS-2:0], ge};
			meta_s[k+1] <= meta_s[k];
		end
	end

	assign out_vld  = vld_s[QUOT_BITS];
	assign out_quot = quot_s[QUOT_BITS];
	assign out_meta = meta_s[QUOT_BITS];

	// partial remainder stays below the divisor on every live word that is neither bad nor saturated
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[1] && !meta_s[1].bad && !meta_s[1].sat) |-> (rem_s[1] < den_s[1]))
		else $error("divider remainder not below divisor");

	a_rem_below_den_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld && !out_meta.bad && !out_meta.sat) |->
			(rem_s[QUOT_BITS] < den_s[QUOT_BITS]))
		else $error("final remainder not below divisor");

	a_vld_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_vld |-> ##(QUOT_BITS) out_vld)
		else $error("divider lost a word");

endmodule

// ===== design/interpolated_flat_field_correction.sv =====
// Top level: flat-field correction with interpolated flats and dark subtraction.
// Depends on iffc_pkg and iffc_divider.
//
// Usage:
//   Pulse start with the four pixel values and frame_end to hand in one word;
//   busy is always low, so a word may be given in every clock cycle.
//   Each word yields one result word, shown for a single cycle with done high:
//   transmission (unsigned Q8.16, saturated), invalid and frame_end_out.
//   A word passes the difference, multiply, denominator and check stages, the
//   24 divider stages (one quotient bit per divider stage) and the output register;
//   throughput is one word per cycle, set by the fully pipelined 24-stage divider.
//   The receiver cannot stall: the pipeline moves every cycle and results are
//   never held back or dropped.
//   Register second_flat_weight (signed Q4.16) is written through the APB
//   port at byte address 0 and must only change while no word is in flight.
//   Reset (arst_n low) clears the weight to 0 and empties the pipeline;
//   no result is presented until new words arrive.
module interpolated_flat_field_correction #(
	parameter int PIXEL_BITS = iffc_pkg::PIXEL_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [15:0]                    sample_pixel,
	input  logic [15:0]                    dark_pixel,
	input  logic [15:0]                    first_flat_pixel,
	input  logic [15:0]                    second_flat_pixel,
	input  logic                           frame_end,
	output logic                           done,
	output logic [iffc_pkg::TRANS_BITS-1:0] transmission,
	output logic                           invalid,
	output logic                           frame_end_out,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [iffc_pkg::ADDR_BITS-1:0] paddr,
	input  logic [iffc_pkg::DATA_BITS-1:0] pwdata,
	output logic [iffc_pkg::DATA_BITS-1:0] prdata,
	output logic                           pready
);
	import iffc_pkg::*;

	localparam int DIFF_W  = PIXEL_BITS + 1;
	localparam int PROD_W  = WEIGHT_BITS + DIFF_W;
	localparam int DEN_W   = PROD_W + 1;
	localparam int DIV_W   = DEN_W - 1;
	localparam int LATENCY = 5 + TRANS_BITS;

	// ---------------- configuration ----------------
	logic [WEIGHT_BITS-1:0] weight_q;
	logic                   wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready &&
		(paddr[ADDR_BITS-1:2] == REG_WEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= '0;
		end else if (wr_en) begin
			weight_q <= pwdata[WEIGHT_BITS-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[ADDR_BITS-1:2] == REG_WEIGHT) begin
			prdata = {{(DATA_BITS-WEIGHT_BITS){1'b0}}, weight_q};
		end
	end

	assign busy = 1'b0;

	// ---------------- stage 1: differences ----------------
	logic                     vld_s1;
	logic signed [DIFF_W-1:0] flat_diff_s1;
	logic signed [DIFF_W-1:0] base_s1;
	logic signed [DIFF_W-1:0] num_s1;
	logic                     fe_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		flat_diff_s1 <= $signed({1'b0, second_flat_pixel[PIXEL_BITS-1:0]})
			- $signed({1'b0, first_flat_pixel[PIXEL_BITS-1:0]});
		base_s1      <= $signed({1'b0, first_flat_pixel[PIXEL_BITS-1:0]})
			- $signed({1'b0, dark_pixel[PIXEL_BITS-1:0]});
		num_s1       <= $signed({1'b0, sample_pixel[PIXEL_BITS-1:0]})
			- $signed({1'b0, dark_pixel[PIXEL_BITS-1:0]});
		fe_s1        <= frame_end;
	end

	// ---------------- stage 2: weight multiply ----------------
	logic                     vld_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [DIFF_W-1:0] base_s2;
	logic signed [DIFF_W-1:0] num_s2;
	logic                     fe_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= $signed(weight_q) * flat_diff_s1;
		base_s2 <= base_s1;
		num_s2  <= num_s1;
		fe_s2   <= fe_s1;
	end

	// ---------------- stage 3: denominator ----------------
	logic                     vld_s3;
	logic signed [DEN_W-1:0]  den_s3;
	logic signed [DIFF_W-1:0] num_s3;
	logic                     fe_s3;
	logic        [DEN_W-1:0]  base_x;
	logic        [DEN_W-1:0]  prod_x;

	assign base_x = {{(DEN_W-DIFF_W-FRAC_BITS){base_s2[DIFF_W-1]}}, base_s2,
		{FRAC_BITS{1'b0}}};
	assign prod_x = {{(DEN_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		den_s3 <= $signed(base_x + prod_x);
		num_s3 <= num_s2;
		fe_s3  <= fe_s2;
	end

	// ---------------- stage 4: checks, divider setup ----------------
	logic             vld_s4;
	logic [DIV_W-1:0] rem_s4;
	logic [DIV_W-1:0] den_s4;
	meta_t            meta_s4;
	logic             bad;
	logic [DIV_W-1:0] rem0;

	assign bad  = den_s3[DEN_W-1] || (den_s3 == '0) || num_s3[DIFF_W-1] || (num_s3 == '0);
	assign rem0 = {{(DIV_W-PIXEL_BITS-SAT_SHIFT){1'b0}}, num_s3[PIXEL_BITS-1:0],
		{SAT_SHIFT{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	// ratio overflows Q8.16 exactly when num*2^8 >= den
	always_ff @(posedge clk) begin
		rem_s4            <= rem0;
		den_s4            <= den_s3[DIV_W-1:0];
		meta_s4.bad       <= bad;
		meta_s4.sat       <= !bad && (rem0 >= den_s3[DIV_W-1:0]);
		meta_s4.frame_end <= fe_s3;
	end

	// ---------------- divider ----------------
	logic                  div_vld;
	logic [TRANS_BITS-1:0] div_quot;
	meta_t                 div_meta;

	iffc_divider #(
		.DIV_W     (DIV_W),
		.QUOT_BITS (TRANS_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s4),
		.in_rem   (rem_s4),
		.in_den   (den_s4),
		.in_meta  (meta_s4),
		.out_vld  (div_vld),
		.out_quot (div_quot),
		.out_meta (div_meta)
	);

	// ---------------- output register ----------------
	logic                  done_q;
	logic [TRANS_BITS-1:0] trans_q;
	logic                  invalid_q;
	logic                  fe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		priority if (div_meta.bad) begin
			trans_q <= '0;
		end else if (div_meta.sat) begin
			trans_q <= '1;
		end else begin
			trans_q <= div_quot;
		end
		invalid_q <= div_meta.bad;
		fe_q      <= div_meta.frame_end;
	end

	assign done          = done_q;
	assign transmission  = trans_q;
	assign invalid       = invalid_q;
	assign frame_end_out = fe_q;

	// ---------------- checks ----------------
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && invalid) |-> (transmission == '0))
		else $error("invalid result with nonzero transmission");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(LATENCY) done)
		else $error("result word missing after pipeline latency");

	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (frame_end_out == $past(frame_end, LATENCY)))
		else $error("frame_end_out does not follow its word");

	a_weight_wr: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> (weight_q == $past(pwdata[WEIGHT_BITS-1:0])))
		else $error("weight register write lost");

endmodule
